### design/pct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pct_pkg
// Types, sizes and result codes shared by the pending challenge table.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int TableSize = 64;
  localparam int SlotBits  = 6;
  localparam int PeerBits  = 16;
  localparam int QueueDepth = 2;

  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_MATCHED   = 3'd3;
  localparam logic [2:0] ST_UNMATCHED = 3'd4;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_PONG   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [15:0]        peer;
    logic [15:0]        named_peer;
    logic signed [31:0] challenge;
    logic               plain_mode;
    logic [31:0]        now_seconds;
    logic               length_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [SlotBits-1:0] slot;
    logic                last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic               malformed;
    logic               func;
    logic [PeerBits-1:0] peer;
    logic [31:0]        challenge;
    logic               plain_mode;
    logic [31:0]        now_seconds;
  } cmd_t;

endpackage
`default_nettype wire

### design/pct_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pct_in_if / pct_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pct_in_if;
  import pct_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pct_out_if;
  import pct_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/pct_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pct_front
// Accepts input items, checks pong form and queues commands for the back end.
// ----------------------------------------------------------------------------
module pct_front
  import pct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pct_in_if.sink    in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  cmd_t       queue [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_new;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_new.func        = in_ch.data.func;
    cmd_new.peer        = in_ch.data.peer;
    cmd_new.challenge   = in_ch.data.challenge;
    cmd_new.plain_mode  = in_ch.data.plain_mode;
    cmd_new.now_seconds = in_ch.data.now_seconds;
    cmd_new.malformed   = (in_ch.data.func == OP_PONG) &&
                          (!in_ch.data.length_ok ||
                           (in_ch.data.named_peer != in_ch.data.peer));
  end

  assign in_ch.ready = (count != 2'(QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### design/pct_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pct_back
// Holds the table; scans one slot per cycle for create/pong unless stalled.
// ----------------------------------------------------------------------------
module pct_back
  import pct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      cmd,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  pct_out_if.source out_ch,
  output logic      busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  localparam int EntryBits = PeerBits + 32 + 1 + 32;

  logic [EntryBits-1:0] mem [TableSize];
  logic [TableSize-1:0] valid_bits;
  logic [TableSize-1:0] nonzero_time;

  logic [1:0]          state;
  cmd_t                cur;
  logic [SlotBits:0]   idx;
  logic [SlotBits:0]   rd_idx;
  logic [EntryBits-1:0] rd_data;
  logic                rd_live;
  logic [SlotBits-1:0] rd_slot;
  logic [31:0]         best;
  logic                found;
  logic [SlotBits-1:0] pick;
  logic                any_match;

  logic                ov;
  out_item_t           od;
  logic                pend_valid;
  logic                pend_hold;
  out_item_t           pend;

  logic [PeerBits-1:0] e_peer;
  logic [31:0]         e_chal;
  logic                e_plain;
  logic [31:0]         e_time;
  logic                hit;
  logic                scan_done;

  assign {e_peer, e_chal, e_plain, e_time} = rd_data;
  assign hit = rd_live && valid_bits[rd_slot] && e_peer == cur.peer &&
               e_chal == cur.challenge && e_plain == cur.plain_mode;

  assign out_ch.valid = ov;
  assign out_ch.data  = od;
  assign cmd_ready = (state == S_IDLE) && !pend_valid;
  assign busy = (state != S_IDLE) || pend_valid || ov;
  assign scan_done = idx[SlotBits];

  // registered read; cleared slots read as zero
  always_ff @(posedge clk) begin
    rd_data <= mem[idx[SlotBits-1:0]];
    if (!nonzero_time[idx[SlotBits-1:0]]) rd_data <= '0;
    if (state == S_WRITE) begin
      mem[pick] <= {cur.peer, cur.challenge, cur.plain_mode, cur.now_seconds};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid_bits   <= '0;
      nonzero_time <= '0;
      idx          <= '0;
      rd_live      <= 1'b0;
      ov           <= 1'b0;
      pend_valid   <= 1'b0;
      pend_hold    <= 1'b0;
      found        <= 1'b0;
      any_match    <= 1'b0;
    end else begin
      if (ov && out_ch.ready) ov <= 1'b0;
      if (pend_valid && !pend_hold && (!ov || out_ch.ready)) begin
        ov <= 1'b1;
        od <= pend;
        pend_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          rd_live <= 1'b0;
          if (cmd_valid && !pend_valid) begin
            cur <= cmd;
            if (cmd.malformed) begin
              pend_valid <= 1'b1;
              pend <= '{status: ST_MALFORMED, slot: '0, last: 1'b1};
            end else begin
              state     <= S_SCAN;
              idx       <= '0;
              best      <= cmd.now_seconds;
              found     <= 1'b0;
              any_match <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // stall the scan while a held match cannot move to the output
          if (!(pend_valid && hit && cur.func == OP_PONG && ov && !out_ch.ready)) begin
            if (!scan_done) idx <= idx + 1'b1;
            rd_live <= !scan_done;
            rd_idx  <= idx;
            if (rd_live) begin
              if (cur.func == OP_CREATE) begin
                if (e_time < best) begin
                  best  <= e_time;
                  found <= 1'b1;
                  pick  <= rd_slot;
                end
              end else if (hit) begin
                // a newer match means the held one is not the last
                if (pend_valid) begin
                  ov <= 1'b1;
                  od <= pend;
                end
                valid_bits[rd_slot]   <= 1'b0;
                nonzero_time[rd_slot] <= 1'b0;
                any_match  <= 1'b1;
                pend_valid <= 1'b1;
                pend_hold  <= 1'b1;
                pend <= '{status: ST_MATCHED, slot: rd_slot, last: 1'b0};
              end
            end
            if (scan_done && !rd_live) state <= S_FINAL;
          end else begin
            rd_live <= 1'b0;
            idx     <= rd_idx;
          end
        end
        S_WRITE: begin
          valid_bits[pick]   <= 1'b1;
          nonzero_time[pick] <= (cur.now_seconds != 32'd0);
          state <= S_IDLE;
        end
        S_FINAL: begin
          if (cur.func == OP_PONG && any_match) begin
            // release the held last match with last set
            pend.last <= 1'b1;
            pend_hold <= 1'b0;
            state     <= S_IDLE;
          end else if (!pend_valid) begin
            pend_valid <= 1'b1;
            if (cur.func == OP_CREATE) begin
              if (found) begin
                pend  <= '{status: ST_CREATED, slot: pick, last: 1'b1};
                state <= S_WRITE;
              end else begin
                pend  <= '{status: ST_FULL, slot: '0, last: 1'b1};
                state <= S_IDLE;
              end
            end else begin
              pend  <= '{status: ST_UNMATCHED, slot: '0, last: 1'b1};
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rd_slot = rd_idx[SlotBits-1:0];

endmodule
`default_nettype wire

### design/pending_challenge_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pending_challenge_table_unit
// Table of pending ping challenges with create and pong handling.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch (valid/ready), results leave on out_ch.
// A create scans all 64 slots, one per cycle, for the oldest send time and
// gives one result. A pong that is well formed scans all slots and gives
// one result per matched slot, the last one flagged; the last match is
// held until the scan ends. An unmatched pong gives one result. A malformed
// pong is answered without a scan. The table memory has one read port; the
// slot scan must end before the back end takes the next item.
// A two-entry queue lets new items transfer while the scan runs.
// Reset clears the queue, all valid bits and the output register at once.
// When out_ch stalls, the scan holds on a new match until the output frees.
// ----------------------------------------------------------------------------
module pending_challenge_table_unit
  import pct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pct_in_if.sink    in_ch,
  pct_out_if.source out_ch
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  logic busy;

  pct_front u_front (
    .clk, .rst, .in_ch, .cmd, .cmd_valid, .cmd_ready
  );

  pct_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready, .out_ch, .busy
  );

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.data.status <= ST_UNMATCHED))
    else $error("status out of range");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.data.status == ST_FULL ||
                     out_ch.data.status == ST_MALFORMED ||
                     out_ch.data.status == ST_UNMATCHED)
      |-> (out_ch.data.slot == '0 && out_ch.data.last))
    else $error("single result with bad slot or last");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> busy)
    else $error("back end idle after handoff");

endmodule
`default_nettype wire
